// ===== sv/ufn_pkg.sv =====
// Shared types, code point constants and decode functions for the UTF-8 normalizer.
`default_nettype none
package ufn_pkg;

  localparam int ByteW   = 8;
  localparam int HoldN   = 3;
  localparam int ResN    = 4;
  localparam int CpW     = 21;

  localparam logic [CpW-1:0] CpFwLo     = 21'h00FF01;
  localparam logic [CpW-1:0] CpFwHi     = 21'h00FF5E;
  localparam logic [CpW-1:0] CpFwOffset = 21'h00FEE0;
  localparam logic [CpW-1:0] CpTab      = 21'h000009;
  localparam logic [CpW-1:0] CpNbsp     = 21'h0000A0;
  localparam logic [CpW-1:0] CpIdeoSp   = 21'h003000;
  localparam logic [CpW-1:0] CpNnbsp    = 21'h00202F;
  localparam logic [CpW-1:0] CpMmsp     = 21'h00205F;
  localparam logic [CpW-1:0] CpBom      = 21'h00FEFF;
  localparam logic [CpW-1:0] CpSpLo     = 21'h002000;
  localparam logic [CpW-1:0] CpSpHi     = 21'h00200D;
  localparam logic [CpW-1:0] CpIdeoCom  = 21'h003001;
  localparam logic [CpW-1:0] CpIdeoStop = 21'h003002;
  localparam logic [CpW-1:0] CpLdquo    = 21'h00201C;
  localparam logic [CpW-1:0] CpRdquo    = 21'h00201D;
  localparam logic [CpW-1:0] CpLsquo    = 21'h002018;
  localparam logic [CpW-1:0] CpRsquo    = 21'h002019;
  localparam logic [CpW-1:0] CpEmDash   = 21'h002014;
  localparam logic [CpW-1:0] CpHorBar   = 21'h002015;
  localparam logic [CpW-1:0] CpLdAngle  = 21'h00300A;
  localparam logic [CpW-1:0] CpRdAngle  = 21'h00300B;

  localparam logic [ByteW-1:0] AscSpace = 8'h20;
  localparam logic [ByteW-1:0] AscComma = 8'h2C;
  localparam logic [ByteW-1:0] AscStop  = 8'h2E;
  localparam logic [ByteW-1:0] AscDquo  = 8'h22;
  localparam logic [ByteW-1:0] AscSquo  = 8'h27;
  localparam logic [ByteW-1:0] AscDash  = 8'h2D;
  localparam logic [ByteW-1:0] AscLt    = 8'h3C;
  localparam logic [ByteW-1:0] AscGt    = 8'h3E;

  // Bytes produced by one request, first byte in slot 0.
  typedef struct packed {
    logic [ResN-1:0][ByteW-1:0] bytes;
    logic [2:0]                 cnt;
    logic                       last;
  } ufn_res_t;

  typedef struct packed {
    ufn_res_t                    res;
    logic [HoldN-1:0][ByteW-1:0] held;
    logic [1:0]                  held_cnt;
  } ufn_parse_t;

  // Sequence length from the lead byte; zero for an invalid lead.
  function automatic logic [2:0] seq_len(input logic [ByteW-1:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) len = 3'd1;
    else if (b[7:5] == 3'b110) len = 3'd2;
    else if (b[7:4] == 4'b1110) len = 3'd3;
    else if (b[7:3] == 5'b11110) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  function automatic logic [CpW-1:0] decode(input logic [3:0][ByteW-1:0] p,
                                            input logic [2:0] len);
    logic [CpW-1:0] u;
    case (len)
      3'd1:    u = {13'd0, p[0]};
      3'd2:    u = {10'd0, p[0][4:0], p[1][5:0]};
      3'd3:    u = {5'd0, p[0][3:0], p[1][5:0], p[2][5:0]};
      default: u = {p[0][2:0], p[1][5:0], p[2][5:0], p[3][5:0]};
    endcase
    return u;
  endfunction

  // ASCII replacement, or zero when the code point passes unchanged.
  function automatic logic [ByteW-1:0] replace(input logic [CpW-1:0] u);
    logic [CpW-1:0]   diff;
    logic [ByteW-1:0] r;
    diff = u - CpFwOffset;
    if (u >= CpFwLo && u <= CpFwHi) r = diff[ByteW-1:0];
    else if (u inside {CpTab, CpNbsp, CpIdeoSp, CpNnbsp, CpMmsp, CpBom, [CpSpLo:CpSpHi]})
      r = AscSpace;
    else if (u == CpIdeoCom) r = AscComma;
    else if (u == CpIdeoStop) r = AscStop;
    else if (u inside {CpLdquo, CpRdquo}) r = AscDquo;
    else if (u inside {CpLsquo, CpRsquo}) r = AscSquo;
    else if (u inside {CpEmDash, CpHorBar}) r = AscDash;
    else if (u == CpLdAngle) r = AscLt;
    else if (u == CpRdAngle) r = AscGt;
    else r = '0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/utf8_fullwidth_normalizer.sv =====
// Top level: input register, held sequence state, parser and result buffer.
// An accepted request waits in the input register until the result buffer can load
// its parsed bytes. Throughput: one request per cycle while out_ready is high and
// each request yields at most one byte. A request yielding more than one byte holds
// the result buffer until its bytes have left by the single output port. Reset
// (synchronous, rst_n low) empties input register, held sequence and result buffer.
`default_nettype none
module utf8_fullwidth_normalizer
  import ufn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] out_byte,
  output logic             out_last
);

  logic                        in_vld_r, in_vld_nxt;
  logic [ByteW-1:0]            in_byte_r;
  logic                        in_last_r;
  logic [HoldN-1:0][ByteW-1:0] held_r;
  logic [1:0]                  held_cnt_r;
  logic                        adv;
  logic                        load_ok;
  ufn_parse_t                  parse;

  assign adv      = in_vld_r && load_ok;
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) in_vld_nxt = 1'b1;
    else if (adv) in_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      held_r     <= '0;
      held_cnt_r <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (adv) begin
        held_r     <= parse.held;
        held_cnt_r <= parse.held_cnt;
      end
    end
  end

  ufn_parse u_parse (
    .held_bytes (held_r),
    .held_count (held_cnt_r),
    .in_byte    (in_byte_r),
    .in_last    (in_last_r),
    .parse      (parse)
  );

  ufn_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (parse.res),
    .out_ready (out_ready),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef SYNTH
  // A held sequence is always an incomplete prefix of a multibyte lead.
  a_held_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (held_cnt_r != 2'd0) |-> (seq_len(held_r[0]) > {1'b0, held_cnt_r}))
    else $error("held bytes do not form an incomplete sequence");

  a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> (held_cnt_r == 2'd0))
    else $error("end of string left bytes held");

  a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (held_cnt_r >= 2'd2) |-> (held_r[1] != '0))
    else $error("zero byte stored in held sequence");
`endif

endmodule
`default_nettype wire

// ===== sv/ufn_parse.sv =====
// Combinational parse of held bytes plus one new byte into output bytes and new held state.
`default_nettype none
module ufn_parse
  import ufn_pkg::*;
(
  input  logic [HoldN-1:0][ByteW-1:0] held_bytes,
  input  logic [1:0]                  held_count,
  input  logic [ByteW-1:0]            in_byte,
  input  logic                        in_last,
  output ufn_parse_t                  parse
);

  always_comb begin
    logic [ResN-1:0][ByteW-1:0] buf_b;
    logic [6:0][ByteW-1:0]      ext;
    logic [2:0]                 n;
    logic [ResN-1:0][2:0]       len_a;
    logic [ResN-1:0][ByteW-1:0] repl_a;
    logic [3:0][ByteW-1:0]      win;
    logic [ResN-1:0]            keep;
    logic [ResN-1:0][ByteW-1:0] val;
    logic [2:0]                 nxt;
    logic [2:0]                 hold_start;
    logic [2:0]                 pos;
    logic [2:0]                 idx;
    logic [2:0]                 diff;
    logic                       raw_run;
    logic                       stop;

    buf_b = {8'd0, held_bytes};
    n     = {1'b0, held_count};
    if (in_byte != '0) begin
      buf_b[held_count] = in_byte;
      n = n + 3'd1;
    end
    ext = {24'd0, buf_b};

    // Decode a candidate sequence at every start position in parallel.
    for (int i = 0; i < ResN; i++) begin
      win       = {ext[i+3], ext[i+2], ext[i+1], ext[i]};
      len_a[i]  = seq_len(ext[i]);
      repl_a[i] = replace(decode(win, len_a[i]));
    end

    // Walk the sequence starts left to right.
    nxt        = '0;
    raw_run    = 1'b0;
    stop       = 1'b0;
    hold_start = n;
    for (int i = 0; i < ResN; i++) begin
      keep[i] = 1'b0;
      val[i]  = buf_b[i];
      if (!stop && 3'(i) < n) begin
        if (3'(i) == nxt) begin
          if (len_a[i] == 3'd0) begin
            keep[i] = 1'b1;
            nxt     = 3'(i) + 3'd1;
          end else if (3'(i) + len_a[i] <= n) begin
            keep[i] = 1'b1;
            nxt     = 3'(i) + len_a[i];
            if (repl_a[i] != '0) begin
              val[i]  = repl_a[i];
              raw_run = 1'b0;
            end else begin
              raw_run = 1'b1;
            end
          end else if (in_last) begin
            // flush: emit the open lead raw, reparse what follows
            keep[i] = 1'b1;
            nxt     = 3'(i) + 3'd1;
          end else begin
            stop       = 1'b1;
            hold_start = 3'(i);
          end
        end else begin
          keep[i] = raw_run;
        end
      end
    end

    // Pack kept bytes to the front.
    parse.res.bytes = '0;
    pos = '0;
    for (int i = 0; i < ResN; i++) begin
      if (keep[i]) begin
        parse.res.bytes[pos[1:0]] = val[i];
        pos = pos + 3'd1;
      end
    end
    parse.res.cnt  = pos;
    parse.res.last = in_last;

    for (int k = 0; k < HoldN; k++) begin
      idx = hold_start + 3'(k);
      parse.held[k] = (idx < n) ? ext[idx] : '0;
    end
    diff           = n - hold_start;
    parse.held_cnt = diff[1:0];
  end

endmodule
`default_nettype wire

// ===== sv/ufn_outq.sv =====
// Result buffer: holds the bytes of one request and drains them one per cycle while out_ready is high.
`default_nettype none
module ufn_outq
  import ufn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ufn_res_t         res,
  input  logic             out_ready,
  output logic             load_ok,
  output logic             out_valid,
  output logic [ByteW-1:0] out_byte,
  output logic             out_last
);

  logic [ResN-1:0][ByteW-1:0] q_r, q_nxt;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic                       last_r, last_nxt;
  logic                       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_byte  = q_r[0];
  assign out_last  = last_r && (cnt_r == 3'd1);
  assign pop       = out_valid && out_ready;
  assign load_ok   = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready);

  always_comb begin
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (load) begin
      q_nxt    = res.bytes;
      cnt_nxt  = res.cnt;
      last_nxt = res.last;
    end else if (pop) begin
      // advance to the next byte
      q_nxt   = {8'd0, q_r[ResN-1:1]};
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire
